FILE: rtl/qrr_pkg.sv
// Shared types, widths and codes for the quadratic real root solver.
// Used by every module of the block; depends on nothing else.
package qrr_pkg;

  // Fixed field widths of the coefficient and root items.
  localparam int COEF_WIDTH    = 16;
  localparam int OUT_FRAC_BITS = 16;
  localparam int ROOT_WIDTH    = 32;

  // Exact discriminant, its nonnegative radicand and the floored square root.
  localparam int DISC_WIDTH = 2 * COEF_WIDTH + 3;
  localparam int RAD_WIDTH  = 2 * COEF_WIDTH + 2;
  localparam int SQRT_WIDTH = RAD_WIDTH / 2;

  // Numerator magnitude |-b +/- s|, the scaled dividend and the divisor |2a|.
  localparam int NUM_WIDTH = COEF_WIDTH + 2;
  localparam int QUO_WIDTH = NUM_WIDTH + OUT_FRAC_BITS;
  localparam int DEN_WIDTH = COEF_WIDTH + 1;

  // Solution kinds.
  localparam logic [1:0] KIND_A_ZERO   = 2'd0;
  localparam logic [1:0] KIND_REPEATED = 2'd1;
  localparam logic [1:0] KIND_TWO_REAL = 2'd2;
  localparam logic [1:0] KIND_COMPLEX  = 2'd3;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;
  } coefs_t;

  typedef struct packed {
    logic [1:0]                   root_kind;
    logic signed [ROOT_WIDTH-1:0] root_large;
    logic signed [ROOT_WIDTH-1:0] root_small;
    logic                         overflow_flag;
  } roots_t;

  // Side data that rides along the square root pipeline.
  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
  } sqrt_side_t;

  // Side data that rides along the divider pipeline.
  typedef struct packed {
    logic [1:0] kind;
    logic       neg_p;
    logic       neg_m;
  } div_side_t;

endpackage

FILE: rtl/qrr_disc.sv
// Two-stage discriminant unit: products b*b and a*c, then D = b*b - 4ac and kind.
// Depends on qrr_pkg.
module qrr_disc (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  qrr_pkg::coefs_t                  coefs,
  output logic                             out_valid,
  output logic [qrr_pkg::RAD_WIDTH-1:0]    rad,
  output qrr_pkg::sqrt_side_t              side
);

  logic                                    v1;
  logic signed [2*qrr_pkg::COEF_WIDTH-1:0] bb;
  logic signed [2*qrr_pkg::COEF_WIDTH-1:0] ac;
  logic signed [qrr_pkg::COEF_WIDTH-1:0]   a1;
  logic signed [qrr_pkg::COEF_WIDTH-1:0]   b1;
  logic signed [qrr_pkg::DISC_WIDTH-1:0]   disc;
  logic [1:0]                              kind_next;

  // First stage: the two products.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bb <= coefs.coef_b * coefs.coef_b;
      ac <= coefs.coef_a * coefs.coef_c;
      a1 <= coefs.coef_a;
      b1 <= coefs.coef_b;
    end
  end

  // Second stage: exact discriminant and the solution kind.
  always_comb begin
    disc = qrr_pkg::DISC_WIDTH'(bb) - (qrr_pkg::DISC_WIDTH'(ac) <<< 2);
    if (a1 == '0) begin
      kind_next = qrr_pkg::KIND_A_ZERO;
    end else if (disc < 0) begin
      kind_next = qrr_pkg::KIND_COMPLEX;
    end else if (disc == '0) begin
      kind_next = qrr_pkg::KIND_REPEATED;
    end else begin
      kind_next = qrr_pkg::KIND_TWO_REAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad         <= (disc < 0) ? '0 : disc[qrr_pkg::RAD_WIDTH-1:0];
      side.kind   <= kind_next;
      side.coef_a <= a1;
      side.coef_b <= b1;
    end
  end

endmodule

FILE: rtl/qrr_sqrt.sv
// Pipelined floored square root, one result bit per register stage.
// Depends on qrr_pkg.
module qrr_sqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [qrr_pkg::RAD_WIDTH-1:0]    rad,
  input  qrr_pkg::sqrt_side_t              side_in,
  output logic                             out_valid,
  output logic [qrr_pkg::SQRT_WIDTH-1:0]   root,
  output qrr_pkg::sqrt_side_t              side_out
);

  localparam int S = qrr_pkg::SQRT_WIDTH;

  logic                            v    [0:S];
  logic [S+1:0]                    rem  [0:S];
  logic [S-1:0]                    res  [0:S];
  logic [qrr_pkg::RAD_WIDTH-1:0]   radr [0:S];
  qrr_pkg::sqrt_side_t             sd   [0:S];

  assign v[0]    = in_valid;
  assign rem[0]  = '0;
  assign res[0]  = '0;
  assign radr[0] = rad;
  assign sd[0]   = side_in;

  // Each stage brings down two radicand bits and decides one root bit.
  for (genvar i = 0; i < S; i++) begin : g_stage
    logic [S+1:0] rem_shift;
    logic [S+1:0] trial;
    logic [S+1:0] rem_next;
    logic [S-1:0] res_next;

    always_comb begin
      rem_shift = {rem[i][S-1:0], radr[i][qrr_pkg::RAD_WIDTH-1 -: 2]};
      trial     = {res[i], 2'b01};
      if (rem_shift >= trial) begin
        rem_next = rem_shift - trial;
        res_next = {res[i][S-2:0], 1'b1};
      end else begin
        rem_next = rem_shift;
        res_next = {res[i][S-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= rem_next;
        res[i+1]  <= res_next;
        radr[i+1] <= radr[i] << 2;
        sd[i+1]   <= sd[i];
      end
    end
  end

  assign out_valid = v[S];
  assign root      = res[S];
  assign side_out  = sd[S];

endmodule

FILE: rtl/qrr_div.sv
// Two-lane pipelined restoring divider, one quotient bit per register stage.
// Depends on qrr_pkg.
module qrr_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [qrr_pkg::QUO_WIDTH-1:0]    num_p,
  input  logic [qrr_pkg::QUO_WIDTH-1:0]    num_m,
  input  logic [qrr_pkg::DEN_WIDTH-1:0]    den,
  input  qrr_pkg::div_side_t               side_in,
  output logic                             out_valid,
  output logic [qrr_pkg::QUO_WIDTH-1:0]    quo_p,
  output logic [qrr_pkg::QUO_WIDTH-1:0]    quo_m,
  output qrr_pkg::div_side_t               side_out
);

  localparam int Q = qrr_pkg::QUO_WIDTH;
  localparam int D = qrr_pkg::DEN_WIDTH;

  logic               v   [0:Q];
  logic [D-1:0]       dv  [0:Q];
  logic [D-1:0]       rem [0:Q][0:1];
  logic [Q-1:0]       nq  [0:Q][0:1];
  qrr_pkg::div_side_t sd  [0:Q];

  assign v[0]      = in_valid;
  assign dv[0]     = den;
  assign rem[0][0] = '0;
  assign rem[0][1] = '0;
  assign nq[0][0]  = num_p;
  assign nq[0][1]  = num_m;
  assign sd[0]     = side_in;

  for (genvar i = 0; i < Q; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[i+1] <= dv[i];
        sd[i+1] <= sd[i];
      end
    end

    // Both lanes share the divisor; the dividend shifts out as quotient bits shift in.
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [D:0]   trial;
      logic [D-1:0] rem_next;
      logic         qbit;

      always_comb begin
        trial = {rem[i][l], nq[i][l][Q-1]};
        if (trial >= {1'b0, dv[i]}) begin
          rem_next = D'(trial - {1'b0, dv[i]});
          qbit     = 1'b1;
        end else begin
          rem_next = trial[D-1:0];
          qbit     = 1'b0;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1][l] <= rem_next;
          nq[i+1][l]  <= {nq[i][l][Q-2:0], qbit};
        end
      end
    end
  end

  assign out_valid = v[Q];
  assign quo_p     = nq[Q][0];
  assign quo_m     = nq[Q][1];
  assign side_out  = sd[Q];

endmodule

FILE: rtl/quadratic_real_roots_core.sv
// Top level of the quadratic real root solver: input register, discriminant,
// square root, numerator setup, divider, sign fix and ordered saturating output.
// Depends on qrr_pkg, qrr_disc, qrr_sqrt and qrr_div.

// Takes a*x^2+b*x+c=0 with signed Q8.8 coefficients and gives the solution kind
// plus the larger and smaller real roots in signed Q16.16, saturated with a flag.
// One coefficient item is accepted every cycle while the pipeline is not held; each
// result passes the input stage, two discriminant stages, the 17-stage square root,
// the setup stage, the 34-stage divider (one bit per stage) and two output stages.
// The whole pipeline holds while a result waits under stall, so coefs_stall follows
// roots_valid && roots_stall.
module quadratic_real_roots_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            coefs_valid,
  output logic            coefs_stall,
  input  qrr_pkg::coefs_t coefs,
  output logic            roots_valid,
  input  logic            roots_stall,
  output qrr_pkg::roots_t roots
);

  localparam int Q  = qrr_pkg::QUO_WIDTH;
  localparam int NW = qrr_pkg::NUM_WIDTH;
  localparam int CW = qrr_pkg::COEF_WIDTH;
  localparam logic signed [Q:0] SAT_HI = (Q+1)'(64'sd2147483647);
  localparam logic signed [Q:0] SAT_LO = (Q+1)'(-64'sd2147483648);

  logic                             en;
  logic                             in_v;
  qrr_pkg::coefs_t                  in_q;
  logic                             dc_v;
  logic [qrr_pkg::RAD_WIDTH-1:0]    dc_rad;
  qrr_pkg::sqrt_side_t              dc_side;
  logic                             sq_v;
  logic [qrr_pkg::SQRT_WIDTH-1:0]   sq_root;
  qrr_pkg::sqrt_side_t              sq_side;
  logic signed [NW:0]               n_p;
  logic signed [NW:0]               n_m;
  logic [NW-1:0]                    mag_p;
  logic [NW-1:0]                    mag_m;
  logic [CW-1:0]                    mag_a;
  logic                             p_v;
  logic [Q-1:0]                     p_num_p;
  logic [Q-1:0]                     p_num_m;
  logic [qrr_pkg::DEN_WIDTH-1:0]    p_den;
  qrr_pkg::div_side_t               p_side;
  logic                             dv_v;
  logic [Q-1:0]                     dv_p;
  logic [Q-1:0]                     dv_m;
  qrr_pkg::div_side_t               dv_side;
  logic                             f_v;
  logic signed [Q:0]                f_p;
  logic signed [Q:0]                f_m;
  logic [1:0]                       f_kind;
  logic signed [Q:0]                big;
  logic signed [Q:0]                sml;
  qrr_pkg::roots_t                  roots_next;

  // The whole pipeline advances unless a finished item is held.
  assign en          = !(roots_valid && roots_stall);
  assign coefs_stall = !en;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (en) begin
      in_v <= coefs_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_q <= coefs;
    end
  end

  qrr_disc u_disc (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_v),
    .coefs     (in_q),
    .out_valid (dc_v),
    .rad       (dc_rad),
    .side      (dc_side)
  );

  qrr_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dc_v),
    .rad       (dc_rad),
    .side_in   (dc_side),
    .out_valid (sq_v),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  // Numerators -b +/- s as magnitudes with quotient signs; divisor |2a|.
  always_comb begin
    n_p   = -((NW+1)'(sq_side.coef_b)) + (NW+1)'(sq_root);
    n_m   = -((NW+1)'(sq_side.coef_b)) - (NW+1)'(sq_root);
    mag_p = (n_p < 0) ? NW'(-n_p) : NW'(n_p);
    mag_m = (n_m < 0) ? NW'(-n_m) : NW'(n_m);
    mag_a = (sq_side.coef_a < 0) ? CW'(-sq_side.coef_a) : CW'(sq_side.coef_a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_num_p      <= {mag_p, {qrr_pkg::OUT_FRAC_BITS{1'b0}}};
      p_num_m      <= {mag_m, {qrr_pkg::OUT_FRAC_BITS{1'b0}}};
      p_den        <= {mag_a, 1'b0};
      p_side.kind  <= sq_side.kind;
      p_side.neg_p <= (n_p < 0) ^ (sq_side.coef_a < 0);
      p_side.neg_m <= (n_m < 0) ^ (sq_side.coef_a < 0);
    end
  end

  qrr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_v),
    .num_p     (p_num_p),
    .num_m     (p_num_m),
    .den       (p_den),
    .side_in   (p_side),
    .out_valid (dv_v),
    .quo_p     (dv_p),
    .quo_m     (dv_m),
    .side_out  (dv_side)
  );

  // Restore the quotient signs; truncation toward zero follows from this.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_p    <= dv_side.neg_p ? -$signed({1'b0, dv_p}) : $signed({1'b0, dv_p});
      f_m    <= dv_side.neg_m ? -$signed({1'b0, dv_m}) : $signed({1'b0, dv_m});
      f_kind <= dv_side.kind;
    end
  end

  // Order the roots, saturate each, and zero them when a is zero or the roots are complex.
  always_comb begin
    big = (f_p > f_m) ? f_p : f_m;
    sml = (f_p > f_m) ? f_m : f_p;
    roots_next.root_kind     = f_kind;
    roots_next.overflow_flag = (big > SAT_HI) || (sml < SAT_LO);
    roots_next.root_large    = (big > SAT_HI) ? SAT_HI[qrr_pkg::ROOT_WIDTH-1:0] :
                               (big < SAT_LO) ? SAT_LO[qrr_pkg::ROOT_WIDTH-1:0] :
                               big[qrr_pkg::ROOT_WIDTH-1:0];
    roots_next.root_small    = (sml > SAT_HI) ? SAT_HI[qrr_pkg::ROOT_WIDTH-1:0] :
                               (sml < SAT_LO) ? SAT_LO[qrr_pkg::ROOT_WIDTH-1:0] :
                               sml[qrr_pkg::ROOT_WIDTH-1:0];
    if (f_kind == qrr_pkg::KIND_A_ZERO || f_kind == qrr_pkg::KIND_COMPLEX) begin
      roots_next.root_large    = '0;
      roots_next.root_small    = '0;
      roots_next.overflow_flag = 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      roots_valid <= 1'b0;
    end else if (en) begin
      roots_valid <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roots <= roots_next;
    end
  end

  // A result for a zero a or for complex roots carries zero roots and no overflow.
  a_no_root_zero: assert property (@(posedge clk) disable iff (rst)
    roots_valid && (roots.root_kind == qrr_pkg::KIND_A_ZERO ||
                    roots.root_kind == qrr_pkg::KIND_COMPLEX)
    |-> roots.root_large == '0 && roots.root_small == '0 && !roots.overflow_flag)
    else $error("nonzero roots reported without a real root");

  // A repeated root is reported the same in both fields.
  a_repeated_equal: assert property (@(posedge clk) disable iff (rst)
    roots_valid && roots.root_kind == qrr_pkg::KIND_REPEATED
    |-> roots.root_large == roots.root_small)
    else $error("repeated root reported with two values");

  // The roots are always ordered.
  a_ordered: assert property (@(posedge clk) disable iff (rst)
    roots_valid |-> roots.root_large >= roots.root_small)
    else $error("larger root below smaller root");

endmodule

FILE: tb/sv/tb.sv
// Testbench for quadratic_real_roots_core: drives coefficient items and checks
// each root item against a built-in fixed-point solver, with random idling.
// Depends on qrr_pkg and the quadratic_real_roots_core RTL.
`timescale 1ns / 1ps

module tb;

  localparam int LATENCY    = 57;
  localparam int IDLE_PCT   = 7;
  localparam int STUCK_MAX  = 2000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             coefs_valid = 1'b0;
  logic             coefs_stall;
  qrr_pkg::coefs_t  coefs = '0;
  logic             roots_valid;
  logic             roots_stall = 1'b0;
  qrr_pkg::roots_t  roots;

  qrr_pkg::roots_t  expected_roots[$];
  int               error_count = 0;
  int               stuck_cycles = 0;
  bit               steady = 1'b0;

  quadratic_real_roots_core dut (
    .clk(clk), .rst(rst),
    .coefs_valid(coefs_valid), .coefs_stall(coefs_stall), .coefs(coefs),
    .roots_valid(roots_valid), .roots_stall(roots_stall), .roots(roots)
  );

  always #10 clk = ~clk;

  // Floored integer square root by bitwise search.
  function automatic longint floor_sqrt(longint v);
    longint r;
    longint t;
    r = 0;
    for (int i = 20; i >= 0; i--) begin
      t = r | (longint'(1) << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Clamps a root to the signed 32-bit range and notes any clipping.
  function automatic longint clamp_root(longint v, inout bit clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Works out the solution kind and the ordered Q16.16 roots.
  function automatic qrr_pkg::roots_t solve_quadratic(qrr_pkg::coefs_t q);
    longint          a, b, c, disc, s, den, r1, r2;
    bit              clipped;
    qrr_pkg::roots_t r;
    r = '0;
    clipped = 1'b0;
    a = longint'($signed(q.coef_a));
    b = longint'($signed(q.coef_b));
    c = longint'($signed(q.coef_c));
    if (a == 0) begin
      r.root_kind = qrr_pkg::KIND_A_ZERO;
    end else begin
      disc = b * b - 4 * a * c;
      if (disc < 0) begin
        r.root_kind = qrr_pkg::KIND_COMPLEX;
      end else begin
        s = floor_sqrt(disc);
        den = 2 * a;
        r1 = ((-b + s) << qrr_pkg::OUT_FRAC_BITS) / den;
        r2 = ((-b - s) << qrr_pkg::OUT_FRAC_BITS) / den;
        r.root_kind = (disc == 0) ? qrr_pkg::KIND_REPEATED : qrr_pkg::KIND_TWO_REAL;
        r.root_large = 32'(clamp_root((r1 > r2) ? r1 : r2, clipped));
        r.root_small = 32'(clamp_root((r1 > r2) ? r2 : r1, clipped));
      end
    end
    r.overflow_flag = clipped;
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // Receiver side: random stall, result check and the no-progress watchdog.
  always @(posedge clk) begin
    qrr_pkg::roots_t want;
    if (rst) begin
      stuck_cycles <= 0;
    end else begin
      if (roots_valid && !roots_stall) begin
        if (expected_roots.size() == 0) begin
          report("unexpected item", 0, 0);
        end else begin
          want = expected_roots.pop_front();
          if (roots.root_kind != want.root_kind)
            report("root_kind", longint'(roots.root_kind), longint'(want.root_kind));
          if (roots.root_large != want.root_large)
            report("root_large", longint'(roots.root_large), longint'(want.root_large));
          if (roots.root_small != want.root_small)
            report("root_small", longint'(roots.root_small), longint'(want.root_small));
          if (roots.overflow_flag != want.overflow_flag)
            report("overflow_flag", longint'(roots.overflow_flag),
                   longint'(want.overflow_flag));
        end
      end
      if ((roots_valid && !roots_stall) || (coefs_valid && !coefs_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_MAX) begin
        $display("quadratic_real_roots_core verification failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
    roots_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Sends one item, with an occasional idle cycle ahead of it.
  task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] c);
    qrr_pkg::coefs_t q;
    q.coef_a = a;
    q.coef_b = b;
    q.coef_c = c;
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      coefs_valid <= 1'b0;
      @(posedge clk);
    end
    coefs_valid <= 1'b1;
    coefs <= q;
    do @(posedge clk); while (coefs_stall);
    expected_roots.push_back(solve_quadratic(q));
  endtask

  function automatic logic signed [15:0] any_coef();
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] near_zero(int span);
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  // Extremes, each solution kind, clipping and a repeated root.
  task automatic test_directed();
    send_coefs(16'sd0, 16'sd256, 16'sd256);
    send_coefs(16'sd0, -16'sd32768, 16'sd32767);
    send_coefs(16'sd256, 16'sd0, -16'sd256);
    send_coefs(16'sd256, -16'sd512, 16'sd256);
    send_coefs(16'sd256, 16'sd0, 16'sd256);
    send_coefs(16'sd1, 16'sd32767, 16'sd0);
    send_coefs(16'sd1, -16'sd32768, 16'sd0);
    send_coefs(-16'sd1, 16'sd32767, 16'sd1);
    send_coefs(16'sd32767, 16'sd32767, 16'sd32767);
    send_coefs(-16'sd32768, -16'sd32768, -16'sd32768);
    send_coefs(-16'sd32768, 16'sd0, 16'sd32767);
    send_coefs(16'sd32767, -16'sd32768, -16'sd32768);
    send_coefs(16'sd3, 16'sd1, 16'sd0);
    send_coefs(16'sd768, 16'sd1, 16'sd0);
    send_coefs(-16'sd256, 16'sd512, -16'sd256);
    send_coefs(16'sd1, 16'sd2, 16'sd1);
    send_coefs(16'sd100, 16'sd7, -16'sd3);
    send_coefs(-16'sd1, -16'sd1, -16'sd1);
  endtask

  // Sender holds off until the pipeline has drained.
  task automatic test_drain_pause();
    coefs_valid <= 1'b0;
    wait (expected_roots.size() == 0);
    @(posedge clk);
    send_coefs(16'sd512, 16'sd256, -16'sd1024);
  endtask

  // Mixed random items with a stretch of steady traffic in the middle.
  task automatic test_random(int count);
    int p, q, sel;
    for (int i = 0; i < count; i++) begin
      steady = (i >= 400 && i < 600);
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        send_coefs(any_coef(), any_coef(), any_coef());
      end else if (sel < 55) begin
        send_coefs(near_zero(512), near_zero(512), near_zero(512));
      end else if (sel < 62) begin
        send_coefs(16'sd0, any_coef(), any_coef());
      end else if (sel < 77) begin
        // Perfect-square discriminant of zero: a = p^2, c = q^2, b = 2pq.
        p = $urandom_range(1, 127);
        q = $urandom_range(0, 90);
        if ($urandom_range(0, 1))
          send_coefs(16'(p * p), 16'(2 * p * q), 16'(q * q));
        else
          send_coefs(16'(-p * p), 16'(-2 * p * q), 16'(-q * q));
      end else if (sel < 90) begin
        // Opposite signs of a and c always give two real roots.
        p = $urandom_range(1, 32767);
        q = $urandom_range(1, 32767);
        if ($urandom_range(0, 1))
          send_coefs(16'(p), any_coef(), 16'(-q));
        else
          send_coefs(16'(-p), any_coef(), 16'(q));
      end else begin
        // Small a against a large b pushes roots toward clipping.
        send_coefs(near_zero(4), any_coef(), near_zero(64));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_random(950);
    coefs_valid <= 1'b0;
    wait (expected_roots.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (error_count == 0) begin
      $display("quadratic_real_roots_core verification clean");
    end else begin
      $display("quadratic_real_roots_core verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/qrr_pkg.sv
rtl/qrr_disc.sv
rtl/qrr_sqrt.sv
rtl/qrr_div.sv
rtl/quadratic_real_roots_core.sv
tb/sv/tb.sv
